FILE: rtl/tpc_pkg.sv
// Package for the typed predicate comparator: payload structs, type codes and order codes.
// Used by the top level of the block; depends on nothing.
`default_nettype none
package tpc_pkg;
  localparam int MaxKeyBytes = 256;
  localparam int KeyAddrW = $clog2(MaxKeyBytes);

  typedef enum logic [3:0] {
    VT_SHORT = 4'd0, VT_INT = 4'd1, VT_LONG = 4'd2, VT_LONGLONG = 4'd3,
    VT_FLOAT = 4'd4, VT_DOUBLE = 4'd5, VT_STRING = 4'd6, VT_VARSTRING = 4'd7,
    VT_PAGEID = 4'd8, VT_OID = 4'd9
  } value_type_t;

  typedef enum logic [1:0] {
    ORD_LESS = 2'd0, ORD_EQUAL = 2'd1, ORD_GREATER = 2'd2
  } order_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_COMPARE = 1'b1;

  localparam logic [2:0] CFG_VALUE_TYPE = 3'd0;
  localparam logic [2:0] CFG_OP_MASK = 3'd1;
  localparam logic [2:0] CFG_REF_WORD = 3'd2;
  localparam logic [2:0] CFG_REF_LENGTH = 3'd3;
  localparam logic [2:0] CFG_FIXED_LENGTH = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [7:0]  byte_index;
    logic [63:0] column_word;
    logic [8:0]  column_length;
    logic        last_element;
  } in_item_t;

  typedef struct packed {
    logic       match;
    logic [1:0] order;
  } out_item_t;

  function automatic order_t cmp_u(input logic [63:0] a, input logic [63:0] b);
    if (a > b) return ORD_GREATER;
    if (a < b) return ORD_LESS;
    return ORD_EQUAL;
  endfunction

  function automatic order_t cmp_s(input logic [63:0] a, input logic [63:0] b);
    return cmp_u({~a[63], a[62:0]}, {~b[63], b[62:0]});
  endfunction

  // Floats compare as sign-magnitude; a NaN or equal zeros give equal.
  function automatic order_t cmp_fp(input logic [63:0] a, input logic [63:0] b,
                                    input logic sa, input logic sb,
                                    input logic na, input logic nb,
                                    input logic za, input logic zb);
    order_t o;
    if (na || nb || (za && zb)) return ORD_EQUAL;
    if (sa != sb) return sa ? ORD_LESS : ORD_GREATER;
    o = cmp_u(a, b);
    if (sa && o == ORD_GREATER) return ORD_LESS;
    if (sa && o == ORD_LESS) return ORD_GREATER;
    return o;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/tpc_ram.sv
// Generic single-port-write, single-read RAM with a registered read port.
// Standalone; used by the typed predicate comparator for the reference string.
`default_nettype none
module tpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/typed_predicate_comparator_top.sv
// Top level of the typed predicate comparator: two-stage pipeline around the reference RAM.
// Depends on tpc_pkg and tpc_ram.
//
// Usage: configure the five registers through the cfg channel while idle, load the
// reference string with write items, then stream compare items on the in channel.
// Every item passes stage one (RAM read, numeric compare), then stage two (byte compare,
// string state update, result register), one item per cycle while the pipeline does
// not hold. Numeric compares produce a result on every item; string compares produce
// one on the item marked last. Write items produce none. The in channel stalls only
// when the result register is full and out_stall is high; the pipeline then holds. A
// write in stage two forwards its byte to a compare reading the same address in stage
// one. Reset clears the registers (op_mask resets to match on equal) and the string state;
// the reference RAM is not cleared and must be written first.
`default_nettype none
module typed_predicate_comparator_top
  import tpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_item_t   out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [3:0]  value_type;
  logic [2:0]  op_mask;
  logic [63:0] reference_word;
  logic [8:0]  reference_length;
  logic [8:0]  fixed_length;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      value_type <= 4'd0;
      op_mask <= 3'd2;
      reference_word <= 64'd0;
      reference_length <= 9'd0;
      fixed_length <= 9'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VALUE_TYPE:   value_type <= cfg_data[3:0];
        CFG_OP_MASK:      op_mask <= cfg_data[2:0];
        CFG_REF_WORD:     reference_word <= cfg_data;
        CFG_REF_LENGTH:   reference_length <= cfg_data[8:0];
        CFG_FIXED_LENGTH: fixed_length <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic accept;
  logic s1_valid;
  in_item_t s1;
  order_t s1_num;
  logic [7:0] ram_rdata;

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept = in_valid && advance;

  logic ram_we;
  assign ram_we = s1_valid && advance && (s1.operation == OP_WRITE);

  // While the pipeline holds, the RAM keeps reading the address of the held item.
  logic [KeyAddrW-1:0] ram_raddr;
  assign ram_raddr = advance ? in_data.byte_index[KeyAddrW-1:0]
                             : s1.byte_index[KeyAddrW-1:0];

  tpc_ram #(.Width(8), .Depth(MaxKeyBytes)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.byte_index[KeyAddrW-1:0]),
    .wdata (s1.column_word[7:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  order_t num_c;
  always_comb begin
    logic [63:0] c, r;
    c = in_data.column_word;
    r = reference_word;
    case (value_type)
      VT_SHORT: num_c = cmp_s({c[15:0], 48'd0}, {r[15:0], 48'd0});
      VT_INT, VT_LONG: num_c = cmp_s({c[31:0], 32'd0}, {r[31:0], 32'd0});
      VT_LONGLONG: num_c = cmp_s(c, r);
      VT_FLOAT: num_c = cmp_fp({33'd0, c[30:0]}, {33'd0, r[30:0]}, c[31], r[31],
                               (&c[30:23]) && (|c[22:0]), (&r[30:23]) && (|r[22:0]),
                               c[30:0] == 31'd0, r[30:0] == 31'd0);
      VT_DOUBLE: num_c = cmp_fp({1'b0, c[62:0]}, {1'b0, r[62:0]}, c[63], r[63],
                                (&c[62:52]) && (|c[51:0]), (&r[62:52]) && (|r[51:0]),
                                c[62:0] == 63'd0, r[62:0] == 63'd0);
      VT_PAGEID: num_c = cmp_s({c[47:32], c[31:0] ^ 32'h8000_0000, 16'd0},
                               {r[47:32], r[31:0] ^ 32'h8000_0000, 16'd0});
      VT_OID: num_c = cmp_s({c[63:48], c[47:16] ^ 32'h8000_0000, c[15:0] ^ 16'h8000},
                            {r[63:48], r[47:16] ^ 32'h8000_0000, r[15:0] ^ 16'h8000});
      default: num_c = ORD_EQUAL;
    endcase
  end

  logic fwd;
  logic [7:0] fwd_byte;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
    if (advance) begin
      s1 <= in_data;
      s1_num <= num_c;
      fwd <= ram_we && (s1.byte_index == in_data.byte_index);
      fwd_byte <= s1.column_word[7:0];
    end
  end

  order_t running_order;
  logic order_decided;
  logic [7:0] rb;
  logic [8:0] limit;
  logic is_str;
  order_t str_o;
  order_t run_upd;
  logic dec_upd;

  assign rb = fwd ? fwd_byte : ram_rdata;
  assign is_str = (value_type == VT_STRING) || (value_type == VT_VARSTRING);
  assign limit = (value_type == VT_STRING) ? fixed_length :
                 ((s1.column_length < reference_length) ? s1.column_length
                                                        : reference_length);

  always_comb begin
    run_upd = running_order;
    dec_upd = order_decided;
    if (!order_decided && ({1'b0, s1.byte_index} < limit)) begin
      if (s1.column_word[7:0] > rb) begin
        run_upd = ORD_GREATER;
        dec_upd = 1'b1;
      end else if (s1.column_word[7:0] < rb) begin
        run_upd = ORD_LESS;
        dec_upd = 1'b1;
      end
    end
    str_o = run_upd;
    if (value_type == VT_VARSTRING) begin
      if (s1.column_length > reference_length) str_o = ORD_GREATER;
      else if (s1.column_length < reference_length) str_o = ORD_LESS;
    end
  end

  logic s1_cmp;
  order_t res_o;
  assign s1_cmp = s1_valid && (s1.operation == OP_COMPARE);
  assign res_o = is_str ? str_o : s1_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      running_order <= ORD_EQUAL;
      order_decided <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_cmp && (!is_str || s1.last_element);
      if (s1_cmp && is_str) begin
        if (s1.last_element) begin
          running_order <= ORD_EQUAL;
          order_decided <= 1'b0;
        end else begin
          running_order <= run_upd;
          order_decided <= dec_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.order <= res_o;
      out_data.match <= op_mask[res_o];
    end
  end
endmodule
`default_nettype wire
